// ----- hw/rtl/dtb_pkg.sv -----
// Shared constants, opcodes and the saturating-add helper function of the deadline timer bank.
`default_nettype none
package dtb_pkg;

	localparam int TIMER_COUNT = 8;
	localparam int TIME_WIDTH = 32;
	localparam int SEQ_WIDTH = 8;
	localparam int CFG_WIDTH = 31;
	localparam int OFFSET_WIDTH = 8;

	localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int TREE_LEVELS = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 0;
	localparam int TREE_LEAVES = 1 << TREE_LEVELS;
	localparam int TREE_NODES = 2 * TREE_LEAVES - 1;

	localparam logic [CFG_WIDTH-1:0] INTERVAL_RESET = CFG_WIDTH'(100);

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [SEQ_WIDTH-1:0] seq_t;

	typedef enum logic [2:0] {
		OP_SET_TIME  = 3'd0,
		OP_START     = 3'd1,
		OP_STOP      = 3'd2,
		OP_START_ACK = 3'd3,
		OP_STOP_ACK  = 3'd4,
		OP_CHECK     = 3'd5,
		OP_CHECK_ACK = 3'd6,
		OP_NONE      = 3'd7
	} opcode_t;

	function automatic time_t sat_add(input time_t a, input time_t b);
		logic [TIME_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_WIDTH] ? '1 : s[TIME_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dtb_min_tree.sv -----
// Minimum tree over the live deadlines of the timer bank.
`default_nettype none
module dtb_min_tree (
	input  dtb_pkg::time_t deadline [dtb_pkg::TIMER_COUNT],
	output dtb_pkg::time_t earliest,
	output logic           live
);

	dtb_pkg::time_t node_val [dtb_pkg::TREE_NODES];
	logic           node_vld [dtb_pkg::TREE_NODES];

	genvar gi;
	generate
		for (gi = 0; gi < dtb_pkg::TREE_LEAVES; gi++) begin : g_leaf
			if (gi < dtb_pkg::TIMER_COUNT) begin : g_used
				assign node_val[dtb_pkg::TREE_LEAVES - 1 + gi] = deadline[gi];
				assign node_vld[dtb_pkg::TREE_LEAVES - 1 + gi] = (deadline[gi] != '0);
			end else begin : g_pad
				assign node_val[dtb_pkg::TREE_LEAVES - 1 + gi] = '1;
				assign node_vld[dtb_pkg::TREE_LEAVES - 1 + gi] = 1'b0;
			end
		end
		for (gi = 0; gi < dtb_pkg::TREE_LEAVES - 1; gi++) begin : g_node
			always_comb begin
				if (node_vld[2*gi+1] &&
				    (!node_vld[2*gi+2] || node_val[2*gi+1] <= node_val[2*gi+2])) begin
					node_val[gi] = node_val[2*gi+1];
				end else begin
					node_val[gi] = node_val[2*gi+2];
				end
				node_vld[gi] = node_vld[2*gi+1] || node_vld[2*gi+2];
			end
		end
	endgenerate

	assign live = node_vld[0];
	assign earliest = node_vld[0] ? node_val[0] : '1;

endmodule
`default_nettype wire

// ----- hw/rtl/deadline_timer_bank.sv -----
// Top level of the deadline timer bank: stream ports, timer state and result register.
//
// The bank holds eight data deadline timers and one ack timer and executes one
// opcode per input transaction. Each transaction is captured in an input
// register, its effect on the timer state is computed combinationally
// (saturating deadline sums, expiry search against the registered earliest
// deadline and a minimum tree over the updated deadlines) and written into the
// state registers and the result register at the same clock edge. The block
// therefore sustains one transaction per cycle unless the output stream
// stalls, and the result reaches the output stream from the result register.
// The rate is set by the state update through the minimum tree. Writes to the
// timeout interval are accepted at any time on the configuration channel.
`default_nettype none
module deadline_timer_bank (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [30:0] cfg_data,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [2:0] timer_index, [10:3] sequence_req, [42:11] new_time, [47:43] zero
	input  wire logic [47:0] s_axis_tdata,
	// [2:0] opcode
	input  wire logic [2:0]  s_axis_tuser,

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] timer_expired, [3:1] expired_index, [11:4] expired_sequence,
	// [12] ack_expired, [44:13] earliest_deadline, [45] any_running, [47:46] zero
	output logic [47:0]      m_axis_tdata
);

	localparam int TC = dtb_pkg::TIMER_COUNT;
	localparam int TW = dtb_pkg::TIME_WIDTH;

	// Timer state.
	dtb_pkg::time_t                  deadline_q [TC];
	dtb_pkg::seq_t                   sequence_q [TC];
	dtb_pkg::time_t                  earliest_q;
	logic                            live_q;
	dtb_pkg::time_t                  ack_deadline_q;
	logic [dtb_pkg::OFFSET_WIDTH-1:0] offset_q;
	dtb_pkg::time_t                  now_q;
	logic [dtb_pkg::CFG_WIDTH-1:0]   interval_q;

	// Input stage.
	logic                            valid_s1;
	dtb_pkg::opcode_t                opcode_s1;
	logic [2:0]                      index_s1;
	logic [7:0]                      seq_s1;
	logic [31:0]                     time_s1;

	// Output register.
	logic                            out_valid_q;
	logic [47:0]                     out_data_q;

	logic                            advance;

	// Next-state logic.
	dtb_pkg::time_t                  deadline_d [TC];
	dtb_pkg::seq_t                   sequence_d [TC];
	dtb_pkg::time_t                  ack_deadline_d;
	logic [dtb_pkg::OFFSET_WIDTH-1:0] offset_d;
	dtb_pkg::time_t                  now_d;
	dtb_pkg::time_t                  earliest_d;
	logic                            live_d;

	dtb_pkg::time_t                  interval_t;
	dtb_pkg::time_t                  half_interval_t;
	dtb_pkg::time_t                  start_deadline;
	logic                            slot_ok;
	logic [dtb_pkg::IDX_W-1:0]       slot;
	logic                            hit;
	logic [dtb_pkg::IDX_W-1:0]       hit_idx;
	dtb_pkg::seq_t                   hit_seq;
	logic                            ack_hit;

	assign cfg_ready = 1'b1;
	assign advance = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	assign interval_t = TW'(interval_q);
	assign half_interval_t = TW'(interval_q >> 1);
	assign start_deadline = dtb_pkg::sat_add(dtb_pkg::sat_add(now_q, interval_t), TW'(offset_q));
	assign slot_ok = (32'(index_s1) < TC);
	assign slot = dtb_pkg::IDX_W'(index_s1);

	always_comb begin
		deadline_d = deadline_q;
		sequence_d = sequence_q;
		ack_deadline_d = ack_deadline_q;
		offset_d = offset_q;
		now_d = now_q;
		hit = 1'b0;
		hit_idx = '0;
		hit_seq = '0;
		ack_hit = 1'b0;
		case (opcode_s1)
			dtb_pkg::OP_SET_TIME: begin
				now_d = TW'(time_s1);
				offset_d = '0;
			end
			dtb_pkg::OP_START: begin
				if (slot_ok) begin
					deadline_d[slot] = start_deadline;
					sequence_d[slot] = dtb_pkg::SEQ_WIDTH'(seq_s1);
					offset_d = offset_q + dtb_pkg::OFFSET_WIDTH'(1);
				end
			end
			dtb_pkg::OP_STOP: begin
				if (slot_ok) begin
					deadline_d[slot] = '0;
				end
			end
			dtb_pkg::OP_START_ACK: begin
				ack_deadline_d = dtb_pkg::sat_add(now_q, half_interval_t);
				offset_d = offset_q + dtb_pkg::OFFSET_WIDTH'(1);
			end
			dtb_pkg::OP_STOP_ACK: begin
				ack_deadline_d = '0;
			end
			dtb_pkg::OP_CHECK: begin
				if (live_q && now_q >= earliest_q) begin
					for (int i = TC - 1; i >= 0; i--) begin
						if (deadline_q[i] != '0 && deadline_q[i] == earliest_q) begin
							hit = 1'b1;
							hit_idx = dtb_pkg::IDX_W'(i);
						end
					end
					hit_seq = sequence_q[hit_idx];
					if (hit) begin
						deadline_d[hit_idx] = '0;
					end
				end
			end
			dtb_pkg::OP_CHECK_ACK: begin
				if (ack_deadline_q != '0 && now_q >= ack_deadline_q) begin
					ack_deadline_d = '0;
					ack_hit = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	dtb_min_tree u_min_tree (
		.deadline (deadline_d),
		.earliest (earliest_d),
		.live     (live_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1 <= dtb_pkg::opcode_t'(s_axis_tuser);
			index_s1 <= s_axis_tdata[2:0];
			seq_s1 <= s_axis_tdata[10:3];
			time_s1 <= s_axis_tdata[42:11];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= dtb_pkg::INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TC; i++) begin
				deadline_q[i] <= '0;
				sequence_q[i] <= '0;
			end
			earliest_q <= '1;
			live_q <= 1'b0;
			ack_deadline_q <= '0;
			offset_q <= '0;
			now_q <= '0;
		end else if (valid_s1 && advance) begin
			deadline_q <= deadline_d;
			sequence_q <= sequence_d;
			earliest_q <= earliest_d;
			live_q <= live_d;
			ack_deadline_q <= ack_deadline_d;
			offset_q <= offset_d;
			now_q <= now_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_data_q <= {2'b00, live_d, 32'(earliest_d), ack_hit, 8'(hit_seq),
				3'(hit_idx), hit};
		end
	end

endmodule
`default_nettype wire
